// ===== rtl/pen_pressure_tilt_conditioner_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Pen pressure/tilt conditioner assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef PEN_PRESSURE_TILT_CONDITIONER_UNIT_MACROS_SVH
`define PEN_PRESSURE_TILT_CONDITIONER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define PPTC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pptc assertion failed");

// next-cycle implication
`define PPTC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pptc assertion failed");

`else

`define PPTC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PPTC_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/pptc_pkg.sv =====
// ----------------------------------------------------------------------------
// Pen pressure/tilt conditioner package
// Shared constants, codes and the sideband word carried down the pipeline.
// ----------------------------------------------------------------------------
package pptc_pkg;

    localparam int TABLE_DEPTH_DEF = 256;

    // divider: quotient bits and restoring steps per pipeline stage
    localparam int QW        = 16;
    localparam int DIV_STEPS = 4;

    localparam logic [15:0] FULL_SCALE = 16'hFFFF;

    // operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    // configuration register indexes
    localparam logic [2:0] CFG_RAW_MIN   = 3'd0;
    localparam logic [2:0] CFG_RAW_MAX   = 3'd1;
    localparam logic [2:0] CFG_CURVE_EN  = 3'd2;
    localparam logic [2:0] CFG_ROT_EN    = 3'd3;
    localparam logic [2:0] CFG_TILT_COS  = 3'd4;
    localparam logic [2:0] CFG_TILT_SIN  = 3'd5;

    // per-word sideband
    typedef struct packed {
        logic               op;
        logic [7:0]         eidx;
        logic [15:0]        eval;
        logic               byp;
        logic [15:0]        bval;
        logic signed [15:0] xo;
        logic signed [15:0] yo;
    } t_side;

endpackage

// ===== rtl/pptc_smp_if.sv =====
// ----------------------------------------------------------------------------
// Pen sample channel
// Valid/ready channel carrying one sample or table write word.
// ----------------------------------------------------------------------------
interface pptc_smp_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [15:0]        raw_pressure;
    logic signed [15:0] x_tilt;
    logic signed [15:0] y_tilt;
    logic [7:0]         entry_index;
    logic [15:0]        entry_value;

    modport source (
        output valid, operation, raw_pressure, x_tilt, y_tilt, entry_index, entry_value,
        input  ready
    );
    modport sink (
        input  valid, operation, raw_pressure, x_tilt, y_tilt, entry_index, entry_value,
        output ready
    );
endinterface

// ===== rtl/pptc_res_if.sv =====
// ----------------------------------------------------------------------------
// Conditioned result channel
// Valid/ready channel carrying one conditioned pen sample.
// ----------------------------------------------------------------------------
interface pptc_res_if;
    logic               valid;
    logic               ready;
    logic [15:0]        pressure_out;
    logic signed [15:0] x_tilt_out;
    logic signed [15:0] y_tilt_out;

    modport source (output valid, pressure_out, x_tilt_out, y_tilt_out, input ready);
    modport sink   (input valid, pressure_out, x_tilt_out, y_tilt_out, output ready);
endinterface

// ===== rtl/pptc_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// 32/16 division with a 16-bit quotient, DIV_STEPS quotient bits per stage.
// ----------------------------------------------------------------------------
module pptc_div import pptc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  logic [31:0] i_num,
    input  logic [15:0] i_span,
    input  t_side       i_side,
    output logic        o_vld,
    output logic [15:0] o_q,
    output t_side       o_side
);
    localparam int NST = QW / DIV_STEPS;

    logic        r_vld  [NST];
    logic [15:0] r_rem  [NST];
    logic [15:0] r_low  [NST];
    logic [15:0] r_span [NST];
    t_side       r_side [NST];
    logic [15:0] n_rem  [NST];
    logic [15:0] n_low  [NST];

    // run DIV_STEPS compare/subtract steps per stage
    always_comb begin
        logic [15:0] rem;
        logic [15:0] low;
        logic [15:0] spn;
        logic [16:0] t;
        for (int s = 0; s < NST; s++) begin
            if (s == 0) begin
                rem = i_num[31:16];
                low = i_num[15:0];
                spn = i_span;
            end else begin
                rem = r_rem[s-1];
                low = r_low[s-1];
                spn = r_span[s-1];
            end
            for (int k = 0; k < DIV_STEPS; k++) begin
                t   = {rem, low[15]};
                low = {low[14:0], 1'b0};
                if (t >= {1'b0, spn}) begin
                    t      = t - {1'b0, spn};
                    low[0] = 1'b1;
                end
                rem = t[15:0];
            end
            n_rem[s] = rem;
            n_low[s] = low;
        end
    end

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NST; s++) r_vld[s] <= 1'b0;
        end else if (i_en) begin
            for (int s = 0; s < NST; s++) r_vld[s] <= (s == 0) ? i_vld : r_vld[s-1];
        end
    end

    // advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < NST; s++) begin
                r_rem[s]  <= n_rem[s];
                r_low[s]  <= n_low[s];
                r_span[s] <= (s == 0) ? i_span : r_span[s-1];
                r_side[s] <= (s == 0) ? i_side : r_side[s-1];
            end
        end
    end

    assign o_vld  = r_vld[NST-1];
    assign o_q    = r_low[NST-1];
    assign o_side = r_side[NST-1];
endmodule

// ===== rtl/pptc_curve.sv =====
// ----------------------------------------------------------------------------
// Response curve stages
// Table lookup with linear interpolation; also applies table writes in order.
// ----------------------------------------------------------------------------
module pptc_curve import pptc_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_curve_en,
    input  logic               i_vld,
    input  logic [15:0]        i_press,
    input  t_side              i_side,
    output logic               o_vld,
    output logic [15:0]        o_press,
    output logic signed [15:0] o_xo,
    output logic signed [15:0] o_yo
);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int TW = 16 + AW;
    localparam logic [AW-1:0] DM1 = AW'(TABLE_DEPTH - 1);

    logic [15:0] r_mem [TABLE_DEPTH];

    // stage 1: scale to table positions
    logic          r_c1_vld;
    logic [15:0]   r_c1_press;
    logic [TW-1:0] r_c1_t;
    t_side         r_c1_side;
    // stage 2: entry and fraction
    logic          r_c2_vld;
    logic [15:0]   r_c2_press;
    logic [AW-1:0] r_c2_idx;
    logic [15:0]   r_c2_frac;
    t_side         r_c2_side;
    // stage 3: table read
    logic          r_c3_vld;
    logic [15:0]   r_c3_press;
    logic [15:0]   r_c3_frac;
    logic [15:0]   r_c3_a;
    logic [15:0]   r_c3_b;
    t_side         r_c3_side;
    // stage 4: products
    logic          r_c4_vld;
    logic [15:0]   r_c4_press;
    logic [31:0]   r_c4_ma;
    logic [31:0]   r_c4_mb;
    t_side         r_c4_side;
    // stage 5: output register
    logic               r_c5_vld;
    logic [15:0]        r_c5_press;
    logic signed [15:0] r_c5_xo;
    logic signed [15:0] r_c5_yo;

    logic [AW-1:0] n_c2_idx;
    logic [15:0]   n_c2_frac;
    logic [AW-1:0] w_addr_b;
    logic          w_wr;
    logic [15:0]   n_c5_press;

    // split position into entry and fraction (divide by full scale)
    always_comb begin
        logic [AW-1:0] q0;
        logic [16:0]   rem;
        q0  = r_c1_t[TW-1:16];
        rem = 17'(r_c1_t[15:0]) + 17'(q0);
        if (rem >= 17'(FULL_SCALE)) begin
            n_c2_idx  = q0 + AW'(1);
            n_c2_frac = 16'(rem - 17'(FULL_SCALE));
        end else begin
            n_c2_idx  = q0;
            n_c2_frac = rem[15:0];
        end
    end

    // hold the last entry at the top
    assign w_addr_b = (r_c2_idx == DM1) ? r_c2_idx : r_c2_idx + AW'(1);
    assign w_wr     = i_en && r_c2_vld && (r_c2_side.op == OP_WRITE)
                      && (32'(r_c2_side.eidx) < TABLE_DEPTH);

    // interpolated sum divided by full scale, rounded; the remapped pressure passes when the curve is off
    always_comb begin
        logic [31:0] acc;
        logic [15:0] q0;
        logic [16:0] rem;
        logic [16:0] q;
        acc = r_c4_ma + r_c4_mb + 32'd32767;
        q0  = acc[31:16];
        rem = 17'(acc[15:0]) + 17'(q0);
        q   = 17'(q0);
        if (rem >= 17'(FULL_SCALE))       q = q + 17'd1;
        if (rem >= {FULL_SCALE, 1'b0})    q = q + 17'd1;
        n_c5_press = i_curve_en ? q[15:0] : r_c4_press;
    end

    // table write and dual read
    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[AW'(r_c2_side.eidx)] <= r_c2_side.eval;
        if (i_en) begin
            r_c3_a <= r_mem[r_c2_idx];
            r_c3_b <= r_mem[w_addr_b];
        end
    end

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_vld <= 1'b0;
            r_c2_vld <= 1'b0;
            r_c3_vld <= 1'b0;
            r_c4_vld <= 1'b0;
            r_c5_vld <= 1'b0;
        end else if (i_en) begin
            r_c1_vld <= i_vld;
            r_c2_vld <= r_c1_vld;
            r_c3_vld <= r_c2_vld;
            r_c4_vld <= r_c3_vld;
            r_c5_vld <= r_c4_vld && (r_c4_side.op == OP_SAMPLE);
        end
    end

    // advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c1_press <= i_press;
            r_c1_t     <= TW'(i_press) * TW'(DM1);
            r_c1_side  <= i_side;
            r_c2_press <= r_c1_press;
            r_c2_idx   <= n_c2_idx;
            r_c2_frac  <= n_c2_frac;
            r_c2_side  <= r_c1_side;
            r_c3_press <= r_c2_press;
            r_c3_frac  <= r_c2_frac;
            r_c3_side  <= r_c2_side;
            r_c4_press <= r_c3_press;
            r_c4_ma    <= 32'(r_c3_a) * 32'(FULL_SCALE - r_c3_frac);
            r_c4_mb    <= 32'(r_c3_b) * 32'(r_c3_frac);
            r_c4_side  <= r_c3_side;
            r_c5_press <= n_c5_press;
            r_c5_xo    <= r_c4_side.xo;
            r_c5_yo    <= r_c4_side.yo;
        end
    end

    assign o_vld   = r_c5_vld;
    assign o_press = r_c5_press;
    assign o_xo    = r_c5_xo;
    assign o_yo    = r_c5_yo;
endmodule

// ===== rtl/pen_pressure_tilt_conditioner_unit.sv =====
// ----------------------------------------------------------------------------
// Pen pressure/tilt conditioner
// Remaps pen pressure, applies a response curve and rotates the tilt vector.
// ----------------------------------------------------------------------------
// Usage:
//   i_smp takes one word per cycle unless o_res stalls: a pen sample
//   (operation 0) or a response table write (operation 1). Each sample
//   passes eleven register stages and is then presented on o_res; table
//   writes give none. Throughput is one word per cycle while o_res is not
//   stalled, set by the fully pipelined path: a range/product stage, a tilt
//   rounding stage, a four-stage restoring divider for the pressure remap
//   and five curve stages (scale, entry split, table read, products, sum).
//   Table writes take effect in stream order, so a sample taken after a write
//   sees it. Load the table before enabling the curve.
//   Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data; the user
//   must do so only while no word is in flight, the block does not enforce it.
//   Reset clears all valid bits and restores the configuration defaults; table contents are
//   left as they are. When the receiver stalls, the whole pipeline holds and
//   i_smp.ready drops, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "pen_pressure_tilt_conditioner_unit_macros.svh"

module pen_pressure_tilt_conditioner_unit import pptc_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pptc_smp_if.sink    i_smp,
    pptc_res_if.source  o_res,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    // configuration
    logic [15:0]        r_min;
    logic [15:0]        r_max;
    logic               r_curve_en;
    logic               r_rot_en;
    logic signed [15:0] r_cos;
    logic signed [15:0] r_sin;

    logic w_en;

    // stage A
    logic               r_a_vld;
    t_side              r_a_side;
    logic [31:0]        r_a_num;
    logic [15:0]        r_a_span;
    logic signed [31:0] r_a_pxc;
    logic signed [31:0] r_a_pys;
    logic signed [31:0] r_a_pxs;
    logic signed [31:0] r_a_pyc;
    t_side              n_a_side;
    logic [31:0]        n_a_num;
    logic [15:0]        n_a_span;

    // stage B
    logic        r_b_vld;
    t_side       r_b_side;
    logic [31:0] r_b_num;
    logic [15:0] r_b_span;
    t_side       n_b_side;

    // divider output
    logic        w_div_vld;
    logic [15:0] w_div_q;
    t_side       w_div_side;
    logic [15:0] w_press;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min      <= 16'd0;
            r_max      <= FULL_SCALE;
            r_curve_en <= 1'b0;
            r_rot_en   <= 1'b0;
            r_cos      <= 16'sd16384;
            r_sin      <= 16'sd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RAW_MIN:  r_min      <= i_cfg_data;
                CFG_RAW_MAX:  r_max      <= i_cfg_data;
                CFG_CURVE_EN: r_curve_en <= i_cfg_data[0];
                CFG_ROT_EN:   r_rot_en   <= i_cfg_data[0];
                CFG_TILT_COS: r_cos      <= $signed(i_cfg_data);
                CFG_TILT_SIN: r_sin      <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // advance when the output slot is free or being taken
    assign w_en        = !o_res.valid || o_res.ready;
    assign i_smp.ready = w_en;

    // stage A: order the range, build the dividend, flag the clamped cases
    always_comb begin
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] p;
        logic [15:0] diff;
        p  = i_smp.raw_pressure;
        lo = (r_min > r_max) ? r_max : r_min;
        hi = (r_min > r_max) ? r_min : r_max;
        n_a_span = hi - lo;
        diff     = p - lo;
        n_a_num  = {diff, 16'd0} - 32'(diff) + 32'(n_a_span[15:1]);

        n_a_side.op   = i_smp.operation;
        n_a_side.eidx = i_smp.entry_index;
        n_a_side.eval = i_smp.entry_value;
        n_a_side.xo   = i_smp.x_tilt;
        n_a_side.yo   = i_smp.y_tilt;
        n_a_side.byp  = 1'b1;
        n_a_side.bval = 16'd0;
        if (n_a_span == 16'd0) begin
            n_a_side.bval = (p >= hi) ? FULL_SCALE : 16'd0;
        end else if (p <= lo) begin
            n_a_side.bval = 16'd0;
        end else if (p >= hi) begin
            n_a_side.bval = FULL_SCALE;
        end else begin
            n_a_side.byp = 1'b0;
        end
    end

    // stage B: round and saturate the rotated tilt when rotation is on
    always_comb begin
        logic signed [32:0] sx;
        logic signed [32:0] sy;
        logic signed [32:0] hx;
        logic signed [32:0] hy;
        sx = 33'(r_a_pxc) - 33'(r_a_pys) + 33'sd8192;
        sy = 33'(r_a_pxs) + 33'(r_a_pyc) + 33'sd8192;
        hx = sx >>> 14;
        hy = sy >>> 14;
        n_b_side = r_a_side;
        if (r_rot_en) begin
            if (hx > 33'sd32767)       n_b_side.xo = 16'sh7FFF;
            else if (hx < -33'sd32768) n_b_side.xo = -16'sh8000;
            else                       n_b_side.xo = 16'(hx);
            if (hy > 33'sd32767)       n_b_side.yo = 16'sh7FFF;
            else if (hy < -33'sd32768) n_b_side.yo = -16'sh8000;
            else                       n_b_side.yo = 16'(hy);
        end
    end

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= i_smp.valid;
            r_b_vld <= r_a_vld;
        end
    end

    // advance payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_side <= n_a_side;
            r_a_num  <= n_a_num;
            r_a_span <= n_a_span;
            r_a_pxc  <= i_smp.x_tilt * r_cos;
            r_a_pys  <= i_smp.y_tilt * r_sin;
            r_a_pxs  <= i_smp.x_tilt * r_sin;
            r_a_pyc  <= i_smp.y_tilt * r_cos;
            r_b_side <= n_b_side;
            r_b_num  <= r_a_num;
            r_b_span <= r_a_span;
        end
    end

    pptc_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (r_b_vld),
        .i_num  (r_b_num),
        .i_span (r_b_span),
        .i_side (r_b_side),
        .o_vld  (w_div_vld),
        .o_q    (w_div_q),
        .o_side (w_div_side)
    );

    // take the clamped value where the remap saturates
    assign w_press = w_div_side.byp ? w_div_side.bval : w_div_q;

    pptc_curve #(.TABLE_DEPTH(TABLE_DEPTH)) u_curve (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_curve_en(r_curve_en),
        .i_vld     (w_div_vld),
        .i_press   (w_press),
        .i_side    (w_div_side),
        .o_vld     (o_res.valid),
        .o_press   (o_res.pressure_out),
        .o_xo      (o_res.x_tilt_out),
        .o_yo      (o_res.y_tilt_out)
    );

    // no result straight out of reset
    `PPTC_ASSERT_IMP(a_rst_clear, i_clk, i_rst_n, $past(!i_rst_n), !o_res.valid)
    // a stalled pipeline holds the divider output word
    `PPTC_ASSERT_NXT(a_div_hold, i_clk, i_rst_n, !w_en && w_div_vld, w_div_vld && $stable(w_div_q))
    // bypassed stage B word copies x tilt from stage A when rotation is off
    `PPTC_ASSERT_IMP(a_tilt_pass, i_clk, i_rst_n, !r_rot_en, n_b_side.xo == r_a_side.xo)

endmodule

// ===== verif/pptc_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// Pen conditioner test package
// Word types shared by the stimulus and checking code of the testbench.
// ----------------------------------------------------------------------------
package pptc_tb_pkg;
    import pptc_pkg::*;

    typedef struct packed {
        logic               op;
        logic [15:0]        pressure;
        logic signed [15:0] xt;
        logic signed [15:0] yt;
        logic [7:0]         idx;
        logic [15:0]        value;
    } t_pen_word;

    typedef struct packed {
        logic [15:0]        pressure;
        logic signed [15:0] xt;
        logic signed [15:0] yt;
    } t_cond_word;
endpackage

// ===== verif/pen_pressure_tilt_conditioner_unit_test.sv =====
// ----------------------------------------------------------------------------
// Pen conditioner testbench
// Drives samples and table writes under random idling, predicts each
// conditioned word and compares it field by field with the block output.
// ----------------------------------------------------------------------------
module pen_pressure_tilt_conditioner_unit_test;
    import pptc_pkg::*;
    import pptc_tb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 256;
    localparam int LATENCY = 11;
    localparam longint CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;

    pptc_smp_if smp ();
    pptc_res_if res ();

    pen_pressure_tilt_conditioner_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_smp(smp.sink), .o_res(res.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // shadow configuration and response table
    logic [15:0] cfg_min, cfg_max;
    logic cfg_curve, cfg_rot;
    logic signed [15:0] cfg_cos, cfg_sin;
    logic [15:0] resp_table [DEPTH];
    bit table_loaded;

    t_cond_word expected_words[$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit recv_hold = 1'b0;
    int errors = 0;
    int samples_sent = 0;
    int writes_sent = 0;
    int words_checked = 0;
    longint cycles = 0;

    always #1 i_clk = ~i_clk;

    // abort on a runaway run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout at %0t", $time);
            $display("pen_pressure_tilt_conditioner_unit_test: FAIL");
            $finish;
        end
    end

    function automatic logic [15:0] remap_pressure(logic [15:0] p);
        logic [16:0] lo, hi, span;
        logic [47:0] num;
        lo = (cfg_min > cfg_max) ? cfg_max : cfg_min;
        hi = (cfg_min > cfg_max) ? cfg_min : cfg_max;
        span = hi - lo;
        if (span == 0) return (p >= hi) ? 16'hFFFF : 16'h0;
        if (p <= lo) return 16'h0;
        if (p >= hi) return 16'hFFFF;
        num = 48'(p - lo) * 48'd65535 + 48'(span >> 1);
        return 16'(num / span);
    endfunction

    function automatic logic [15:0] apply_curve(logic [15:0] r);
        logic [31:0] t, pos, frac;
        logic [47:0] acc;
        t = 32'(r) * (DEPTH - 1);
        pos = t / 65535;
        frac = t % 65535;
        if (pos >= DEPTH - 1) return resp_table[DEPTH - 1];
        acc = 48'(resp_table[pos]) * 48'(65535 - frac)
            + 48'(resp_table[pos + 1]) * 48'(frac) + 48'd32767;
        return 16'(acc / 65535);
    endfunction

    function automatic logic signed [15:0] scale_sat(longint v);
        longint w, q;
        w = v + 8192;
        q = (w >= 0) ? w / 16384 : -((-w + 16383) / 16384);
        if (q > 32767) return 16'sh7FFF;
        if (q < -32768) return -16'sh8000;
        return 16'(q);
    endfunction

    // update the table or queue the conditioned word
    function automatic void predict_word(t_pen_word w);
        t_cond_word c;
        longint x, y, cs, sn;
        if (w.op == OP_WRITE) begin
            resp_table[w.idx] = w.value;
            return;
        end
        c.pressure = remap_pressure(w.pressure);
        if (cfg_curve) c.pressure = apply_curve(c.pressure);
        x = w.xt; y = w.yt; cs = cfg_cos; sn = cfg_sin;
        c.xt = w.xt;
        c.yt = w.yt;
        if (cfg_rot) begin
            c.xt = scale_sat(x * cs - y * sn);
            c.yt = scale_sat(x * sn + y * cs);
        end
        expected_words.push_back(c);
    endfunction

    // offer one word, idling first; valid stays high until the next idle or drain
    task automatic send_word(t_pen_word w);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            smp.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp.valid <= 1'b1;
        smp.operation <= w.op;
        smp.raw_pressure <= w.pressure;
        smp.x_tilt <= w.xt;
        smp.y_tilt <= w.yt;
        smp.entry_index <= w.idx;
        smp.entry_value <= w.value;
        do @(posedge i_clk); while (!smp.ready);
        predict_word(w);
        if (w.op == OP_WRITE) writes_sent++; else samples_sent++;
    endtask

    task automatic send_sample(logic [15:0] p, logic [15:0] x, logic [15:0] y);
        t_pen_word w;
        w = '{op: OP_SAMPLE, pressure: p, xt: x, yt: y,
              idx: 8'($urandom), value: 16'($urandom)};
        send_word(w);
    endtask

    task automatic send_entry(logic [7:0] idx, logic [15:0] value);
        t_pen_word w;
        w = '{op: OP_WRITE, pressure: 16'($urandom), xt: 16'($urandom),
              yt: 16'($urandom), idx: idx, value: value};
        send_word(w);
    endtask

    task automatic send_random_sample();
        logic [15:0] p;
        case ($urandom_range(5))
            0: p = 16'($urandom_range(3));
            1: p = 16'hFFFF - 16'($urandom_range(3));
            2: p = cfg_min + 16'($urandom_range(2)) - 16'd1;
            3: p = cfg_max + 16'($urandom_range(2)) - 16'd1;
            default: p = 16'($urandom);
        endcase
        send_sample(p, 16'($urandom), 16'($urandom));
    endtask

    // drop valid, wait for the pipeline to drain, then the latency for trailing writes
    task automatic drain();
        smp.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // write a register once nothing is in flight
    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_RAW_MIN:  cfg_min = data;
            CFG_RAW_MAX:  cfg_max = data;
            CFG_CURVE_EN: cfg_curve = data[0];
            CFG_ROT_EN:   cfg_rot = data[0];
            CFG_TILT_COS: cfg_cos = data;
            CFG_TILT_SIN: cfg_sin = data;
            default: ;
        endcase
    endtask

    task automatic set_idling(int snd, int rcv);
        send_idle_pct = snd;
        recv_stall_pct = rcv;
    endtask

    // receiver: random stalls plus a forced hold
    always @(posedge i_clk) begin
        if (!i_rst_n) res.ready <= 1'b0;
        else res.ready <= !recv_hold &&
            !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    // compare each accepted word with the oldest expectation
    always @(posedge i_clk) begin
        t_cond_word e;
        if (i_rst_n && res.valid && res.ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word p=%h x=%h y=%h", $time,
                         res.pressure_out, res.x_tilt_out, res.y_tilt_out);
                errors++;
            end else begin
                e = expected_words.pop_front();
                words_checked++;
                if (res.pressure_out !== e.pressure) begin
                    $display("%0t: pressure expected %h actual %h", $time,
                             e.pressure, res.pressure_out);
                    errors++;
                end
                if (res.x_tilt_out !== e.xt) begin
                    $display("%0t: x tilt expected %h actual %h", $time, e.xt,
                             res.x_tilt_out);
                    errors++;
                end
                if (res.y_tilt_out !== e.yt) begin
                    $display("%0t: y tilt expected %h actual %h", $time, e.yt,
                             res.y_tilt_out);
                    errors++;
                end
            end
        end
    end

    // directed extremes, degenerate and swapped ranges, saturating rotation and a full table load
    task automatic test_directed();
        logic [15:0] corners [4] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF};
        send_sample(16'h0000, 16'sh7FFF, -16'sh8000);
        send_sample(16'hFFFF, -16'sh8000, 16'sh7FFF);
        send_sample(16'h8000, 16'h0000, 16'hFFFF);
        write_reg(CFG_RAW_MIN, 16'd1000);
        write_reg(CFG_RAW_MAX, 16'd1000);
        send_sample(16'd999, 16'd1, 16'd2);
        send_sample(16'd1000, 16'd1, 16'd2);
        drain();
        // swapped range
        write_reg(CFG_RAW_MIN, 16'd50000);
        write_reg(CFG_RAW_MAX, 16'd100);
        send_sample(16'd100, 16'd0, 16'd0);
        send_sample(16'd30000, 16'd0, 16'd0);
        send_sample(16'd50000, 16'd0, 16'd0);
        drain();
        // rotation with out-of-range trig values saturates
        write_reg(CFG_ROT_EN, 16'd1);
        write_reg(CFG_TILT_COS, 16'h7FFF);
        write_reg(CFG_TILT_SIN, 16'h8000);
        for (int i = 0; i < 4; i++) send_sample(16'd40000, corners[i], corners[3 - i]);
        for (int i = 0; i < DEPTH; i++) send_entry(8'(i), 16'($urandom));
        table_loaded = 1'b1;
        send_entry(8'd255, 16'hFFFF);
        drain();
        write_reg(CFG_CURVE_EN, 16'd1);
        write_reg(CFG_RAW_MIN, 16'd0);
        write_reg(CFG_RAW_MAX, 16'hFFFF);
        send_sample(16'h0000, 16'd0, 16'd0);
        send_sample(16'hFFFF, 16'd0, 16'd0);
        send_sample(16'hFFFE, 16'd0, 16'd0);
        drain();
    endtask

    // random phases with a configuration change between them
    task automatic test_random_phase(int snd, int rcv, int count);
        int sel;
        set_idling(snd, rcv);
        sel = $urandom_range(5);
        write_reg(CFG_RAW_MIN, sel == 0 ? 16'h0000 : 16'($urandom));
        write_reg(CFG_RAW_MAX, sel == 1 ? 16'hFFFF : 16'($urandom));
        write_reg(CFG_CURVE_EN, table_loaded ? 16'($urandom_range(1)) : 16'd0);
        write_reg(CFG_ROT_EN, 16'($urandom_range(1)));
        write_reg(CFG_TILT_COS, sel == 2 ? 16'sd16384 :
                  16'($signed($urandom_range(32768)) - 16384));
        write_reg(CFG_TILT_SIN, sel == 3 ? -16'sd16384 :
                  16'($signed($urandom_range(32768)) - 16384));
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(9) == 0) send_entry(8'($urandom), 16'($urandom));
            else send_random_sample();
        end
        drain();
        set_idling(0, 0);
    endtask

    // hold the receiver off so the pipeline fills and stalls its input
    task automatic test_backpressure();
        fork
            begin
                recv_hold = 1'b1;
                repeat (200) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            for (int i = 0; i < 60; i++) send_random_sample();
        join
        drain();
    endtask

    initial begin
        smp.valid = 1'b0;
        smp.operation = OP_SAMPLE;
        smp.raw_pressure = '0;
        smp.x_tilt = '0;
        smp.y_tilt = '0;
        smp.entry_index = '0;
        smp.entry_value = '0;
        cfg_min = 16'h0000;
        cfg_max = 16'hFFFF;
        cfg_curve = 1'b0;
        cfg_rot = 1'b0;
        cfg_cos = 16'sd16384;
        cfg_sin = 16'sd0;
        table_loaded = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_phase(0, 0, 400);
        test_random_phase(62, 0, 400);
        test_random_phase(0, 62, 400);
        test_random_phase(13, 13, 400);
        test_backpressure();
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        $display("covered %0d samples and %0d table writes, %0d words checked",
                 samples_sent, writes_sent, words_checked);
        $display("across range, curve, rotation and idling settings");
        if (errors == 0 && expected_words.size() == 0)
            $display("pen_pressure_tilt_conditioner_unit_test: PASS");
        else
            $display("pen_pressure_tilt_conditioner_unit_test: FAIL");
        $finish;
    end
endmodule
